// ===== rtl/core/kwm_pkg.sv =====
// Shared types and codes for the k-way sorted merge block.
// Holds function codes, status codes and the controller command struct.
// No dependencies.
package kwm_pkg;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic app_rd;
    logic app_wr;
    logic pop_init;
    logic scan_iss;
    logic pop_commit;
    logic clr_all;
    logic res_zero;
  } ctl_cmd_t;

endpackage

// ===== rtl/core/kwm_ctrl.sv =====
// Controller state machine of the k-way sorted merge block.
// Sequences appends, pop scans and clears; depends on kwm_pkg.
module kwm_ctrl #(
  parameter int NUM_LISTS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          func_i,
  output logic                                done_o,
  output kwm_pkg::ctl_cmd_t                   cmd_o,
  output logic [$clog2(NUM_LISTS)-1:0]        scan_idx_o
);
  import kwm_pkg::*;

  localparam int LW  = $clog2(NUM_LISTS);
  localparam int SCW = $clog2(NUM_LISTS + 2);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APP    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_DONE   = 5'b10000
  } ctl_state_e;

  ctl_state_e       state_q, state_d;
  logic [SCW-1:0]   cnt_q, cnt_d;
  logic             accept;

  assign accept     = start && (state_q == S_IDLE);
  assign busy       = (state_q != S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign scan_idx_o = LW'(cnt_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            FUNC_APPEND: begin
              cmd_o.app_rd = 1'b1;
              state_d      = S_APP;
            end
            FUNC_POP: begin
              cmd_o.pop_init = 1'b1;
              cnt_d          = '0;
              state_d        = S_SCAN;
            end
            FUNC_CLEAR: begin
              cmd_o.clr_all  = 1'b1;
              cmd_o.res_zero = 1'b1;
              state_d        = S_DONE;
            end
            default: begin
              cmd_o.res_zero = 1'b1;
              state_d        = S_DONE;
            end
          endcase
        end
      end
      S_APP: begin
        cmd_o.app_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_iss = (int'(cnt_q) < NUM_LISTS);
        cnt_d          = cnt_q + SCW'(1);
        if (cnt_q == SCW'(NUM_LISTS + 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.pop_commit = 1'b1;
        state_d          = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/kwm_dpath.sv =====
// Datapath of the k-way sorted merge block: list state memory, value store,
// scan pipeline with running minimum, and result registers. Depends on kwm_pkg.
module kwm_dpath #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kwm_pkg::ctl_cmd_t             cmd_i,
  input  logic [$clog2(NUM_LISTS)-1:0]  scan_idx_i,
  input  logic [2:0]                    list_id_i,
  input  logic signed [31:0]            value_i,
  output logic signed [31:0]            merged_value_o,
  output logic [2:0]                    source_list_o,
  output logic [1:0]                    status_o
);
  import kwm_pkg::*;

  localparam int LW     = $clog2(NUM_LISTS);
  localparam int LN     = 1 << LW;
  localparam int PW     = $clog2(LIST_DEPTH);
  localparam int CW     = $clog2(LIST_DEPTH + 1);
  localparam int AW     = LW + PW;
  localparam int DDEPTH = 1 << AW;

  // Per-list state word: read pointer above fill count.
  logic [PW+CW-1:0]   st_mem [LN];
  logic [31:0]        dmem [DDEPTH];
  logic [LN-1:0]      lv_q;

  logic [LW-1:0]      st_raddr;
  logic               st_ren;
  logic [PW+CW-1:0]   st_rd_q;
  logic               st_lv_q;
  logic [PW-1:0]      rp_e;
  logic [CW-1:0]      cnt_e;

  logic [2:0]         list_id_q;
  logic [31:0]        value_q;
  logic [LW-1:0]      lid;
  logic               id_ok, full, app_do;
  logic [PW:0]        wsum;
  logic [PW-1:0]      wp;

  logic               s1_vld_q;
  logic [LW-1:0]      s1_idx_q;
  logic               nz;
  logic               s2_vld_q;
  logic [LW-1:0]      s2_idx_q;
  logic [PW-1:0]      s2_rp_q;
  logic [CW-1:0]      s2_cnt_q;
  logic [31:0]        d_rd_q;
  logic               take;

  logic               found_q;
  logic [31:0]        best_val_q;
  logic [LW-1:0]      best_idx_q;
  logic [PW-1:0]      best_rp_q;
  logic [CW-1:0]      best_cnt_q;
  logic [PW-1:0]      rp_next;

  logic [31:0]        res_val_q;
  logic [2:0]         res_src_q;
  logic [1:0]         res_st_q;

  assign st_raddr = cmd_i.app_rd ? LW'(list_id_i) : scan_idx_i;
  assign st_ren   = cmd_i.app_rd | cmd_i.scan_iss;

  always_ff @(posedge clk_i) begin
    if (st_ren) begin
      st_rd_q <= st_mem[st_raddr];
      st_lv_q <= lv_q[st_raddr];
    end
  end

  assign rp_e  = st_lv_q ? st_rd_q[PW+CW-1:CW] : '0;
  assign cnt_e = st_lv_q ? st_rd_q[CW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.app_rd) begin
      list_id_q <= list_id_i;
      value_q   <= value_i;
    end
  end

  assign lid    = LW'(list_id_q);
  assign id_ok  = (int'(list_id_q) < NUM_LISTS);
  assign full   = (cnt_e == CW'(LIST_DEPTH));
  assign app_do = cmd_i.app_wr && id_ok && !full;
  assign wsum   = {1'b0, rp_e} + (PW+1)'(cnt_e);
  assign wp     = (wsum >= (PW+1)'(LIST_DEPTH)) ? PW'(wsum - (PW+1)'(LIST_DEPTH))
                                                : PW'(wsum);

  assign rp_next = (best_rp_q == PW'(LIST_DEPTH - 1)) ? '0 : best_rp_q + PW'(1);

  always_ff @(posedge clk_i) begin
    if (app_do) begin
      dmem[{lid, wp}] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (app_do) begin
      st_mem[lid] <= {rp_e, cnt_e + CW'(1)};
    end else if (cmd_i.pop_commit && found_q) begin
      st_mem[best_idx_q] <= {rp_next, best_cnt_q - CW'(1)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
    end else if (cmd_i.clr_all) begin
      lv_q <= '0;
    end else if (app_do) begin
      lv_q[lid] <= 1'b1;
    end
  end

  // Scan pipeline: state read, head read, compare against the running minimum.
  assign nz = s1_vld_q && (cnt_e != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.scan_iss;
      s2_vld_q <= nz;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= scan_idx_i;
    if (nz) begin
      d_rd_q   <= dmem[{s1_idx_q, rp_e}];
      s2_idx_q <= s1_idx_q;
      s2_rp_q  <= rp_e;
      s2_cnt_q <= cnt_e;
    end
  end

  assign take = s2_vld_q && (!found_q || ($signed(d_rd_q) < $signed(best_val_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.pop_init) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_val_q <= d_rd_q;
      best_idx_q <= s2_idx_q;
      best_rp_q  <= s2_rp_q;
      best_cnt_q <= s2_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.app_wr) begin
      res_val_q <= '0;
      res_src_q <= '0;
      res_st_q  <= app_do ? STATUS_OK : STATUS_FULL;
    end else if (cmd_i.pop_commit) begin
      res_val_q <= found_q ? best_val_q : '0;
      res_src_q <= found_q ? 3'(best_idx_q) : '0;
      res_st_q  <= found_q ? STATUS_OK : STATUS_EMPTY;
    end else if (cmd_i.res_zero) begin
      res_val_q <= '0;
      res_src_q <= '0;
      res_st_q  <= STATUS_OK;
    end
  end

  assign merged_value_o = res_val_q;
  assign source_list_o  = res_src_q;
  assign status_o       = res_st_q;

endmodule

// ===== rtl/core/k_way_sorted_merge.sv =====
// K-way sorted merge: NUM_LISTS FIFO lists with an ascending pop across heads.
// Top level tying kwm_ctrl and kwm_dpath together; depends on kwm_pkg.
//
// A request is taken when start is high and busy is low, and its single result
// appears for one cycle with done_o; the result cannot be held off. An append
// reads the list state, then writes the value if there is room, and gives its
// status with done_o, after which the block is ready again. A clear or an
// unused code goes straight to done. A pop scans the lists one per cycle
// through the list state memory and then the value store, then commits the
// smallest head, if any. Equal heads go to the lowest list number.
module k_way_sorted_merge #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [2:0]         list_id_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic signed [31:0] merged_value_o,
  output logic [2:0]         source_list_o,
  output logic [1:0]         status_o
);
  import kwm_pkg::*;

  ctl_cmd_t                   cmd;
  logic [$clog2(NUM_LISTS)-1:0] scan_idx;

  kwm_ctrl #(
    .NUM_LISTS (NUM_LISTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .done_o     (done_o),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx)
  );

  kwm_dpath #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .scan_idx_i     (scan_idx),
    .list_id_i      (list_id_i),
    .value_i        (value_i),
    .merged_value_o (merged_value_o),
    .source_list_o  (source_list_o),
    .status_o       (status_o)
  );

endmodule
